FILE: rtl/interval_merge_table_top_defines.svh
// Assertion macros used by the top level of this block.
`ifndef INTERVAL_MERGE_TABLE_TOP_DEFINES_SVH
`define INTERVAL_MERGE_TABLE_TOP_DEFINES_SVH

// Checked only outside reset.
`define IMT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define IMT_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/imt_pkg.sv
package imt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_ERASE  = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_MOVE   = 2'd3;

  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_ABSORB = 3'd1;
  localparam logic [2:0] ST_MISS   = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_MERGED = 3'd4;

  // Which result the datapath loads into the output register.
  localparam logic [2:0] EM_FIND   = 3'd0;
  localparam logic [2:0] EM_MISS   = 3'd1;
  localparam logic [2:0] EM_ERASE  = 3'd2;
  localparam logic [2:0] EM_REFUSE = 3'd3;
  localparam logic [2:0] EM_MERGED = 3'd4;
  localparam logic [2:0] EM_FULL   = 3'd5;
  localparam logic [2:0] EM_NEW    = 3'd6;
  localparam logic [2:0] EM_MOVE   = 3'd7;

  typedef struct packed {
    logic       load_in;
    logic       pass_start;
    logic       scan;
    logic       merge_init;
    logic       merge_take;
    logic       inval;
    logic       inval_mn;
    logic       write_new;
    logic       write_move;
    logic       emit;
    logic [2:0] emit_sel;
  } imt_cmd_t;

  typedef struct packed {
    logic       pass_done;
    logic       out_free;
    logic [1:0] mode;
    logic       fh;
    logic       ih;
    logic       refuse;
    logic       mn;
    logic       fr;
  } imt_stat_t;

endpackage

FILE: rtl/imt_dpath.sv
module imt_dpath import imt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  imt_cmd_t    cmd,
  output imt_stat_t   stat,
  input  logic [1:0]  mode,
  input  logic [31:0] start_time,
  input  logic [31:0] end_time,
  input  logic [31:0] target_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] result_ident,
  output logic [31:0] result_start,
  output logic [31:0] result_end,
  output logic        last
);

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] en;
    logic [31:0] st;
  } entry_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic [TABLE_DEPTH-1:0] valid;

  logic [1:0]  op_mode;
  logic [31:0] qs, qe, tid;
  logic [CNT_W-1:0] cnt;
  logic        pv;
  logic [IDX_W-1:0] p_idx;

  logic        fh;
  logic [31:0] fh_st, fh_en, fh_id;
  logic        ih;
  logic [IDX_W-1:0] ih_idx;
  logic [31:0] ih_st, ih_en;
  logic [1:0]  ov_cnt;
  logic [IDX_W-1:0] ov_idx;
  logic [31:0] ov_st, ov_en, ov_id;
  logic        mn;
  logic [IDX_W-1:0] mn_idx;
  logic [31:0] mn_st, mn_en, mn_id;
  logic        fr;
  logic [IDX_W-1:0] fr_idx;

  logic [31:0] ns, ne;
  logic [IDX_W-1:0] mover_idx;
  logic        excl;
  logic [31:0] next_id, nid_inc;

  logic        rd_en, wr_en, e_v, e_ov;
  logic [IDX_W-1:0] wr_addr;
  entry_t      wr_data;

  assign rd_en   = cmd.scan && (cnt < DEPTH_CNT);
  assign wr_en   = (cmd.write_new && fr) || cmd.write_move;
  assign wr_addr = cmd.write_move ? mover_idx : fr_idx;
  assign wr_data = '{id: (cmd.write_move ? tid : next_id), en: ne, st: ns};
  assign nid_inc = next_id + 32'd1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[cnt[IDX_W-1:0]];
    end
  end

  assign e_v  = valid[p_idx];
  assign e_ov = e_v && (rd_q.st <= qe) && (rd_q.en >= qs);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_mode <= mode;
      tid     <= target_id;
      if ((mode == MODE_INSERT || mode == MODE_MOVE) && start_time > end_time) begin
        qs <= end_time;
        qe <= start_time;
      end else begin
        qs <= start_time;
        qe <= end_time;
      end
    end
    if (cmd.merge_init) begin
      ns        <= qs;
      ne        <= qe;
      mover_idx <= ih_idx;
    end
    if (cmd.merge_take) begin
      if (mn_st < ns) ns <= mn_st;
      if (mn_en > ne) ne <= mn_en;
    end
    if (pv) begin
      if (!fh && e_v && rd_q.st <= qs && qs <= rd_q.en) begin
        fh_st <= rd_q.st;
        fh_en <= rd_q.en;
        fh_id <= rd_q.id;
      end
      if (!ih && e_v && rd_q.id == tid) begin
        ih_idx <= p_idx;
        ih_st  <= rd_q.st;
        ih_en  <= rd_q.en;
      end
      if (e_ov && ov_cnt == 2'd0) begin
        ov_idx <= p_idx;
        ov_st  <= rd_q.st;
        ov_en  <= rd_q.en;
        ov_id  <= rd_q.id;
      end
      if (e_ov && !(excl && p_idx == mover_idx) && (!mn || rd_q.st < mn_st)) begin
        mn_idx <= p_idx;
        mn_st  <= rd_q.st;
        mn_en  <= rd_q.en;
        mn_id  <= rd_q.id;
      end
      if (!fr && !e_v) begin
        fr_idx <= p_idx;
      end
    end
    p_idx <= cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      pv      <= 1'b0;
      fh      <= 1'b0;
      ih      <= 1'b0;
      ov_cnt  <= '0;
      mn      <= 1'b0;
      fr      <= 1'b0;
      excl    <= 1'b0;
      valid   <= '0;
      next_id <= 32'd1;
    end else begin
      if (cmd.merge_init) begin
        excl <= (op_mode == MODE_MOVE);
      end
      if (cmd.pass_start) begin
        cnt    <= '0;
        pv     <= 1'b0;
        fh     <= 1'b0;
        ih     <= 1'b0;
        ov_cnt <= '0;
        mn     <= 1'b0;
        fr     <= 1'b0;
      end else begin
        pv <= rd_en;
        if (rd_en) begin
          cnt <= cnt + 1'b1;
        end
        if (pv) begin
          if (!fh && e_v && rd_q.st <= qs && qs <= rd_q.en) fh <= 1'b1;
          if (!ih && e_v && rd_q.id == tid) ih <= 1'b1;
          if (e_ov && ov_cnt != 2'd2) ov_cnt <= ov_cnt + 2'd1;
          if (e_ov && !(excl && p_idx == mover_idx)) mn <= 1'b1;
          if (!e_v) fr <= 1'b1;
        end
      end
      if (cmd.inval) begin
        valid[cmd.inval_mn ? mn_idx : ih_idx] <= 1'b0;
      end
      if (cmd.write_new && fr) begin
        valid[fr_idx] <= 1'b1;
        // Zero is never handed out as an id.
        next_id <= (nid_inc == 32'd0) ? 32'd1 : nid_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= (cmd.emit_sel != EM_MERGED);
      case (cmd.emit_sel)
        EM_FIND: begin
          status       <= fh ? ST_DONE : ST_MISS;
          result_ident <= fh ? fh_id : 32'd0;
          result_start <= fh ? fh_st : 32'd0;
          result_end   <= fh ? fh_en : 32'd0;
        end
        EM_MISS: begin
          status <= ST_MISS; result_ident <= tid; result_start <= '0; result_end <= '0;
        end
        EM_ERASE: begin
          status <= ST_DONE; result_ident <= tid; result_start <= ih_st; result_end <= ih_en;
        end
        EM_REFUSE: begin
          status <= ST_ABSORB; result_ident <= ov_id; result_start <= ov_st;
          result_end <= ov_en;
        end
        EM_MERGED: begin
          status <= ST_MERGED; result_ident <= mn_id; result_start <= mn_st;
          result_end <= mn_en;
        end
        EM_FULL: begin
          status <= ST_FULL; result_ident <= '0; result_start <= qs; result_end <= qe;
        end
        EM_NEW: begin
          status <= ST_DONE; result_ident <= next_id; result_start <= ns; result_end <= ne;
        end
        EM_MOVE: begin
          status <= ST_DONE; result_ident <= tid; result_start <= ns; result_end <= ne;
        end
        default: begin
          status <= ST_MISS; result_ident <= '0; result_start <= '0; result_end <= '0;
        end
      endcase
    end
  end

  assign stat.pass_done = (cnt == DEPTH_CNT) && !pv;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.mode      = op_mode;
  assign stat.fh        = fh;
  assign stat.ih        = ih;
  assign stat.mn        = mn;
  assign stat.fr        = fr;
  // One overlap that already covers the request; a moved interval never absorbs itself.
  assign stat.refuse    = (ov_cnt == 2'd1) && (ov_st <= qs) && (qe <= ov_en) &&
                          !(op_mode == MODE_MOVE && ov_idx == ih_idx);

endmodule

FILE: rtl/imt_ctrl.sv
module imt_ctrl import imt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  imt_stat_t stat,
  output imt_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCANA  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MERGE  = 3'd3;
  localparam logic [2:0] S_MDEC   = 3'd4;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in    = 1'b1;
          cmd.pass_start = 1'b1;
          state_next     = S_SCANA;
        end
      end
      S_SCANA, S_MERGE: begin
        cmd.scan = 1'b1;
        if (stat.pass_done) begin
          state_next = (state == S_SCANA) ? S_DECIDE : S_MDEC;
        end
      end
      S_DECIDE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
          if (stat.mode == MODE_FIND) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_FIND;
          end else if (stat.mode == MODE_ERASE || stat.mode == MODE_MOVE) begin
            if (!stat.ih) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = EM_MISS;
            end else if (stat.mode == MODE_ERASE) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = EM_ERASE;
              cmd.inval    = 1'b1;
            end else if (stat.refuse) begin
              // The moved interval lands inside another one and disappears.
              cmd.emit     = 1'b1;
              cmd.emit_sel = EM_REFUSE;
              cmd.inval    = 1'b1;
            end else begin
              cmd.merge_init = 1'b1;
              cmd.pass_start = 1'b1;
              state_next     = S_MERGE;
            end
          end else if (stat.refuse) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_REFUSE;
          end else begin
            cmd.merge_init = 1'b1;
            cmd.pass_start = 1'b1;
            state_next     = S_MERGE;
          end
        end
      end
      S_MDEC: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.mn) begin
            // Report the lowest remaining overlap, drop it, and rescan.
            cmd.emit_sel   = EM_MERGED;
            cmd.inval      = 1'b1;
            cmd.inval_mn   = 1'b1;
            cmd.merge_take = 1'b1;
            cmd.pass_start = 1'b1;
            state_next     = S_MERGE;
          end else begin
            state_next = S_IDLE;
            if (stat.mode == MODE_MOVE) begin
              cmd.emit_sel   = EM_MOVE;
              cmd.write_move = 1'b1;
            end else if (!stat.fr) begin
              cmd.emit_sel = EM_FULL;
            end else begin
              cmd.emit_sel  = EM_NEW;
              cmd.write_new = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/interval_merge_table_top.sv
// Table of up to TABLE_DEPTH disjoint closed intervals with insert, erase, find and move.
// Every operation makes one scan of the table, one entry per cycle through a single-port
// memory. An insert or move that merges m intervals scans m + 1 more times; find and
// erase make a single scan. One operation is in flight at a time. The next beat is
// accepted while the last result still waits in the output register.
`include "interval_merge_table_top_defines.svh"

module interval_merge_table_top import imt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] start_time,
  input  logic [31:0] end_time,
  input  logic [31:0] target_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] result_ident,
  output logic [31:0] result_start,
  output logic [31:0] result_end,
  output logic        last
);

  imt_cmd_t  cmd;
  imt_stat_t stat;

  imt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  imt_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .start_time   (start_time),
    .end_time     (end_time),
    .target_id    (target_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_ident (result_ident),
    .result_start (result_start),
    .result_end   (result_end),
    .last         (last)
  );

  `IMT_CHECK(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted a second beat")
  `IMT_CHECK(a_emit_free, cmd.emit |-> stat.out_free, "result overwrote a waiting beat")
  `IMT_CHECK(a_new_has_slot, cmd.write_new |-> stat.fr, "new interval without a free entry")
  `IMT_CHECK_ALWAYS(a_reset_clean, rst |=> !out_valid && in_ready, "not idle after reset")

endmodule

FILE: dv/interval_merge_table_checker.sv
module interval_merge_table_checker import imt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] start_time,
  input  logic [31:0] end_time,
  input  logic [31:0] target_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [31:0] result_ident,
  input  logic [31:0] result_start,
  input  logic [31:0] result_end,
  input  logic        last,
  output int          errors,
  output int          pending,
  output logic [31:0] id_counter
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        last;
  } span_result_t;

  span_result_t want_q[$];

  logic [31:0] span_lo [TABLE_DEPTH];
  logic [31:0] span_hi [TABLE_DEPTH];
  logic [31:0] span_id [TABLE_DEPTH];
  logic        span_used [TABLE_DEPTH];
  logic [31:0] next_id;

  assign pending = want_q.size();
  assign id_counter = next_id;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic push(input logic [2:0] st, input logic [31:0] id, input logic [31:0] lo,
                      input logic [31:0] hi, input logic lst);
    span_result_t r;
    r.status = st;
    r.id = id;
    r.lo = lo;
    r.hi = hi;
    r.last = lst;
    want_q = {want_q, r};
  endtask

  function automatic int slot_of(input logic [31:0] id);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (span_used[i] && span_id[i] == id) return i;
    return -1;
  endfunction

  task automatic apply_edit(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] tid);
    int hits [TABLE_DEPTH];
    int n;
    int j;
    int mover;
    int slot;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] nlo;
    logic [31:0] nhi;
    n = 0;
    mover = -1;
    if (op == MODE_FIND) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (span_used[i] && span_lo[i] <= a && a <= span_hi[i]) begin
          push(ST_DONE, span_id[i], span_lo[i], span_hi[i], 1'b1);
          return;
        end
      push(ST_MISS, '0, '0, '0, 1'b1);
      return;
    end
    if (op == MODE_ERASE) begin
      slot = slot_of(tid);
      if (slot < 0) push(ST_MISS, tid, '0, '0, 1'b1);
      else begin
        span_used[slot] = 1'b0;
        push(ST_DONE, tid, span_lo[slot], span_hi[slot], 1'b1);
      end
      return;
    end
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    if (op == MODE_MOVE) begin
      mover = slot_of(tid);
      if (mover < 0) begin
        push(ST_MISS, tid, '0, '0, 1'b1);
        return;
      end
    end
    // Overlapping entries sorted by start; equal starts keep table order.
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (span_used[i] && span_lo[i] <= hi && span_hi[i] >= lo) begin
        j = n;
        while (j > 0 && span_lo[hits[j-1]] > span_lo[i]) begin
          hits[j] = hits[j-1];
          j--;
        end
        hits[j] = i;
        n++;
      end
    if (n == 1 && hits[0] != mover && span_lo[hits[0]] <= lo && hi <= span_hi[hits[0]]) begin
      if (mover >= 0) span_used[mover] = 1'b0;
      push(ST_ABSORB, span_id[hits[0]], span_lo[hits[0]], span_hi[hits[0]], 1'b1);
      return;
    end
    nlo = lo;
    nhi = hi;
    for (int k = 0; k < n; k++) begin
      slot = hits[k];
      if (slot != mover) begin
        if (span_lo[slot] < nlo) nlo = span_lo[slot];
        if (span_hi[slot] > nhi) nhi = span_hi[slot];
        push(ST_MERGED, span_id[slot], span_lo[slot], span_hi[slot], 1'b0);
        span_used[slot] = 1'b0;
      end
    end
    if (mover < 0) begin
      slot = -1;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        if (!span_used[i]) slot = i;
      if (slot < 0) begin
        push(ST_FULL, '0, lo, hi, 1'b1);
        return;
      end
      span_used[slot] = 1'b1;
      span_id[slot] = next_id;
      next_id = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
    end else slot = mover;
    span_lo[slot] = nlo;
    span_hi[slot] = nhi;
    push(ST_DONE, span_id[slot], nlo, nhi, 1'b1);
  endtask

  initial begin
    errors = 0;
    next_id = 32'd1;
    for (int i = 0; i < TABLE_DEPTH; i++) span_used[i] = 1'b0;
  end

  always @(posedge clk) begin
    span_result_t w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) report("result beat with nothing expected");
        else begin
          w = want_q.pop_front();
          if (status !== w.status)
            report($sformatf("status %0d, expected %0d", status, w.status));
          if (result_ident !== w.id)
            report($sformatf("result_ident %0h, expected %0h", result_ident, w.id));
          if (result_start !== w.lo)
            report($sformatf("result_start %0h, expected %0h", result_start, w.lo));
          if (result_end !== w.hi)
            report($sformatf("result_end %0h, expected %0h", result_end, w.hi));
          if (last !== w.last)
            report($sformatf("last %0b, expected %0b", last, w.last));
        end
      end
      if (in_valid && in_ready) apply_edit(mode, start_time, end_time, target_id);
    end
  end

endmodule

FILE: dv/interval_merge_table_top_test.sv
module interval_merge_table_top_test import imt_pkg::*; ();

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [31:0] start_time;
  logic [31:0] end_time;
  logic [31:0] target_id;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [31:0] result_ident;
  logic [31:0] result_start;
  logic [31:0] result_end;
  logic        last;
  int          errors;
  int          pending;
  logic [31:0] id_counter;
  logic        calm;

  interval_merge_table_top u_top (.*);

  interval_merge_table_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The result side stalls in bursts until the quiet tail of the run.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        if (!calm) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 12)) @(negedge clk);
        end
      end
    end
  end

  // Valid stays high until the next call, which may drop it before the new payload.
  task automatic send(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b,
                      input logic [31:0] tid);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    start_time <= a;
    end_time <= b;
    target_id <= tid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 9))
      0: pick_id = $urandom();
      1: pick_id = 32'd0;
      default: pick_id = $urandom_range(1, id_counter);
    endcase
  endfunction

  // Times cluster in a narrow window so that overlaps and merges are common.
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0: pick_time = $urandom();
      1: pick_time = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: pick_time = $urandom_range(0, 400);
    endcase
  endfunction

  initial begin
    logic [31:0] t;
    calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_INSERT;
    start_time = '0;
    end_time = '0;
    target_id = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(MODE_FIND, 32'd5, '0, '0);
    send(MODE_ERASE, '0, '0, 32'd7);
    send(MODE_MOVE, 32'd1, 32'd2, 32'd3);
    send(MODE_INSERT, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send(MODE_INSERT, 32'd50, 32'd10, '0);
    send(MODE_INSERT, 32'd20, 32'd30, '0);
    send(MODE_INSERT, 32'd60, 32'd60, '0);
    send(MODE_INSERT, 32'd60, 32'd70, '0);
    send(MODE_INSERT, 32'd0, 32'd100, '0);
    send(MODE_FIND, 32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(MODE_FIND, 32'd101, '0, '0);
    send(MODE_MOVE, 32'hFFFF_FFF0, 32'hFFFF_FFFE, 32'd7);
    send(MODE_MOVE, 32'd5, 32'd5, 32'd7);
    send(MODE_INSERT, 32'd200, 32'd210, '0);
    send(MODE_MOVE, 32'd205, 32'd220, 32'd8);
    send(MODE_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
    send(MODE_ERASE, '0, '0, 32'd8);

    // Hold off until the table has settled.
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);

    // Fill the table with points past the random window, then overflow it.
    for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
      t = 32'd100_000 + i * 1000;
      send(MODE_INSERT, t, t, '0);
    end
    send(MODE_INSERT, 32'd90_000, 32'd90_000, '0);
    send(MODE_INSERT, 32'd100_000, 32'd200_000, '0);

    for (int i = 0; i < 46; i++) begin
      if (i == 36) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send(MODE_INSERT, pick_time(), pick_time(), $urandom());
        4: send(MODE_ERASE, $urandom(), $urandom(), pick_id());
        5, 6: send(MODE_FIND, pick_time(), $urandom(), $urandom());
        default: send(MODE_MOVE, pick_time(), pick_time(), pick_id());
      endcase
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/imt_pkg.sv
rtl/imt_dpath.sv
rtl/imt_ctrl.sv
rtl/interval_merge_table_top.sv
dv/interval_merge_table_checker.sv
dv/interval_merge_table_top_test.sv
